FILE: rtl/ctce_pkg.sv
package ctce_pkg;

  localparam int SUPPLIER_COUNT_DEF = 64;
  localparam int CUSTOMER_COUNT_DEF = 64;

  localparam int ID_W      = 6;
  localparam int COORD_W   = 16;
  localparam int MASK_W    = 64;
  localparam int COST_W    = 32;
  localparam int POS_W     = 6;
  localparam int CNT_W     = 7;
  localparam int DIST_W    = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DEPOT_X      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEPOT_Y      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COVER_TARGET = 2'd2;

  localparam logic [CNT_W-1:0] COVER_TARGET_RST = 7'd1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef struct packed {
    logic               start;
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] by;
  } dist_req_t;

  typedef struct packed {
    logic              done;
    logic [DIST_W-1:0] leg;
  } dist_rsp_t;

endpackage

FILE: rtl/ctce_dist.sv
module ctce_dist
  import ctce_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  dist_req_t req,
  output dist_rsp_t rsp
);

  localparam int ACC_W  = 2 * COORD_W + 2;
  localparam int ITER   = DIST_W;
  localparam int ITER_W = $clog2(ITER);

  typedef enum logic [4:0] {
    D_IDLE = 5'b00001,
    D_SQX  = 5'b00010,
    D_SQY  = 5'b00100,
    D_ROOT = 5'b01000,
    D_DONE = 5'b10000
  } dstate_t;

  dstate_t             state_r, state_nxt;
  logic [COORD_W-1:0]  dx_r, dx_nxt;
  logic [COORD_W-1:0]  dy_r, dy_nxt;
  logic [ACC_W-1:0]    val_r, val_nxt;
  logic [ACC_W-1:0]    root_r, root_nxt;
  logic [ACC_W-1:0]    bit_r, bit_nxt;
  logic [ITER_W-1:0]   iter_r, iter_nxt;

  logic [COORD_W-1:0]   mul_op;
  logic [2*COORD_W-1:0] prod;
  logic [ACC_W-1:0]     trial;
  logic                 ge;

  assign mul_op = (state_r == D_SQX) ? dx_r : dy_r;
  assign prod   = mul_op * mul_op;
  assign trial  = root_r + bit_r;
  assign ge     = val_r >= trial;

  always_comb begin
    state_nxt = state_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    val_nxt   = val_r;
    root_nxt  = root_r;
    bit_nxt   = bit_r;
    iter_nxt  = iter_r;
    case (state_r)
      D_IDLE: begin
        if (req.start) begin
          dx_nxt    = (req.ax > req.bx) ? req.ax - req.bx : req.bx - req.ax;
          dy_nxt    = (req.ay > req.by) ? req.ay - req.by : req.by - req.ay;
          state_nxt = D_SQX;
        end
      end
      D_SQX: begin
        val_nxt   = ACC_W'(prod);
        state_nxt = D_SQY;
      end
      D_SQY: begin
        val_nxt   = val_r + ACC_W'(prod);
        root_nxt  = '0;
        bit_nxt   = ACC_W'(1) << (2 * (ITER - 1));
        iter_nxt  = ITER_W'(ITER - 1);
        state_nxt = D_ROOT;
      end
      D_ROOT: begin
        if (ge) begin
          val_nxt  = val_r - trial;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (iter_r == '0) begin
          state_nxt = D_DONE;
        end else begin
          iter_nxt = iter_r - 1'b1;
        end
      end
      D_DONE: begin
        state_nxt = D_IDLE;
      end
      default: begin
        state_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    val_r  <= val_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
    iter_r <= iter_nxt;
  end

  assign rsp.done = (state_r == D_DONE);
  assign rsp.leg  = root_r[DIST_W-1:0];

endmodule

FILE: rtl/covering_tour_cost_evaluator_core.sv
// Covering tour cost evaluator.
// Input channel (in_valid / in_stall): one request per item. A load request
// (command 0) writes one supplier entry and never stalls the input. A step
// request (command 1) visits a supplier of the current tour; a step without
// the first flag while no tour is open is dropped and does not stall the input.
// A visited step stalls the input through table reads (S_RD_CUR, S_RD_PREV,
// S_GET_PREV), the shared distance unit (two squarings on one multiplier and a
// 17-step bit-serial square root), the coverage count, eight customers at a
// time, and the decision state. A met target adds the return leg in the same
// distance unit, and any result passes through S_EMIT to load the output,
// which waits there while an earlier result is still held by out_stall.
// Result channel (out_valid / out_stall): one registered result per finished
// tour. A result held by out_stall does not stop the next request from being
// taken; a later result waits until the held one is gone.
// Configuration: cfg_we writes depot_x, depot_y or cover_target at cfg_index,
// only while no step is in work; the user must see to it, the block does not.
// Reset (rst_n low, synchronous) closes any tour, clears cost and coverage,
// sets the depot to 0 and the target to 1. The supplier table is not cleared.
module covering_tour_cost_evaluator_core
  import ctce_pkg::*;
#(
  parameter int SUPPLIER_COUNT = SUPPLIER_COUNT_DEF,
  parameter int CUSTOMER_COUNT = CUSTOMER_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_wdata,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_command,
  input  logic [ID_W-1:0]      in_supplier_id,
  input  logic [COORD_W-1:0]   in_coord_x,
  input  logic [COORD_W-1:0]   in_coord_y,
  input  logic [MASK_W-1:0]    in_cover_mask,
  input  logic                 in_first_of_tour,
  input  logic                 in_last_of_tour,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [COST_W-1:0]    out_tour_cost,
  output logic [POS_W-1:0]     out_stop_position,
  output logic [CNT_W-1:0]     out_covered_count,
  output logic                 out_target_met
);

  localparam int ADDR_W   = (SUPPLIER_COUNT > 1) ? $clog2(SUPPLIER_COUNT) : 1;
  localparam int ENTRY_W  = CUSTOMER_COUNT + 2 * COORD_W;
  localparam int NCHUNK   = (CUSTOMER_COUNT + 7) / 8;
  localparam int PAD_W    = NCHUNK * 8;
  localparam int CHUNK_IW = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam logic [CHUNK_IW-1:0] CHUNK_LAST = CHUNK_IW'(NCHUNK - 1);
  localparam logic [POS_W-1:0]    POS_MAX    = '1;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_RD_CUR   = 11'b00000000010,
    S_RD_PREV  = 11'b00000000100,
    S_GET_PREV = 11'b00000001000,
    S_LEG_GO   = 11'b00000010000,
    S_LEG_WAIT = 11'b00000100000,
    S_COUNT    = 11'b00001000000,
    S_DECIDE   = 11'b00010000000,
    S_RET_GO   = 11'b00100000000,
    S_RET_WAIT = 11'b01000000000,
    S_EMIT     = 11'b10000000000
  } state_t;

  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

  state_t                    state_r, state_nxt;
  logic [COORD_W-1:0]        depot_x_r, depot_x_nxt;
  logic [COORD_W-1:0]        depot_y_r, depot_y_nxt;
  logic [CNT_W-1:0]          cover_target_r, cover_target_nxt;
  logic [CUSTOMER_COUNT-1:0] covered_r, covered_nxt;
  logic [COST_W-1:0]         cost_r, cost_nxt;
  logic [ID_W-1:0]           prev_sup_r, prev_sup_nxt;
  logic [POS_W-1:0]          pos_r, pos_nxt;
  logic                      tour_done_r, tour_done_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic [ID_W-1:0]           it_id_r, it_id_nxt;
  logic                      it_first_r, it_first_nxt;
  logic                      it_last_r, it_last_nxt;
  logic [COORD_W-1:0]        cur_x_r, cur_x_nxt;
  logic [COORD_W-1:0]        cur_y_r, cur_y_nxt;
  logic [CUSTOMER_COUNT-1:0] cur_m_r, cur_m_nxt;
  logic [COORD_W-1:0]        pa_x_r, pa_x_nxt;
  logic [COORD_W-1:0]        pa_y_r, pa_y_nxt;
  logic [CHUNK_IW-1:0]       chunk_r, chunk_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic                      emit_met_r, emit_met_nxt;
  logic [POS_W-1:0]          emit_stop_r, emit_stop_nxt;
  logic [COST_W-1:0]         out_cost_r, out_cost_nxt;
  logic [POS_W-1:0]          out_stop_r, out_stop_nxt;
  logic [CNT_W-1:0]          out_count_r, out_count_nxt;
  logic                      out_met_r, out_met_nxt;

  logic [ENTRY_W-1:0]        mem [SUPPLIER_COUNT];
  logic [ENTRY_W-1:0]        rd_data_r;
  logic                      rd_ok_r;
  logic                      mem_we;
  logic                      rd_en;
  logic [ID_W-1:0]           rd_id;
  logic                      rd_sel_ok;
  logic [COORD_W-1:0]        rd_x;
  logic [COORD_W-1:0]        rd_y;
  logic [CUSTOMER_COUNT-1:0] rd_m;

  logic                      accept;
  dist_req_t                 dreq;
  dist_rsp_t                 drsp;
  logic [COST_W:0]           cost_sum;
  logic [COST_W-1:0]         cost_sat;
  logic [PAD_W-1:0]          padded;
  logic [3:0]                chunk_pc;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign mem_we    = accept && (in_command == CMD_LOAD) &&
                     (32'(in_supplier_id) < SUPPLIER_COUNT);
  assign rd_en     = (state_r == S_RD_CUR) || (state_r == S_RD_PREV);
  assign rd_id     = (state_r == S_RD_CUR) ? it_id_r : prev_sup_r;
  assign rd_sel_ok = 32'(rd_id) < SUPPLIER_COUNT;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ADDR_W'(in_supplier_id)] <= {in_cover_mask[CUSTOMER_COUNT-1:0],
                                       in_coord_y, in_coord_x};
    end
    if (rd_en) begin
      rd_data_r <= mem[ADDR_W'(rd_id)];
      rd_ok_r   <= rd_sel_ok;
    end
  end

  assign rd_x = rd_ok_r ? rd_data_r[COORD_W-1:0] : '0;
  assign rd_y = rd_ok_r ? rd_data_r[2*COORD_W-1:COORD_W] : '0;
  assign rd_m = rd_ok_r ? rd_data_r[ENTRY_W-1:2*COORD_W] : '0;

  assign dreq.start = (state_r == S_LEG_GO) || (state_r == S_RET_GO);
  assign dreq.ax    = (state_r == S_LEG_GO) ? pa_x_r : cur_x_r;
  assign dreq.ay    = (state_r == S_LEG_GO) ? pa_y_r : cur_y_r;
  assign dreq.bx    = (state_r == S_LEG_GO) ? cur_x_r : depot_x_r;
  assign dreq.by    = (state_r == S_LEG_GO) ? cur_y_r : depot_y_r;

  ctce_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  assign cost_sum = {1'b0, cost_r} + (COST_W + 1)'(drsp.leg);
  assign cost_sat = cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];
  assign padded   = PAD_W'(covered_r);
  assign chunk_pc = popcount8(padded[chunk_r*8 +: 8]);

  always_comb begin
    state_nxt        = state_r;
    depot_x_nxt      = depot_x_r;
    depot_y_nxt      = depot_y_r;
    cover_target_nxt = cover_target_r;
    covered_nxt      = covered_r;
    cost_nxt         = cost_r;
    prev_sup_nxt     = prev_sup_r;
    pos_nxt          = pos_r;
    tour_done_nxt    = tour_done_r;
    out_valid_nxt    = out_valid_r && out_stall;
    it_id_nxt        = it_id_r;
    it_first_nxt     = it_first_r;
    it_last_nxt      = it_last_r;
    cur_x_nxt        = cur_x_r;
    cur_y_nxt        = cur_y_r;
    cur_m_nxt        = cur_m_r;
    pa_x_nxt         = pa_x_r;
    pa_y_nxt         = pa_y_r;
    chunk_nxt        = chunk_r;
    count_nxt        = count_r;
    emit_met_nxt     = emit_met_r;
    emit_stop_nxt    = emit_stop_r;
    out_cost_nxt     = out_cost_r;
    out_stop_nxt     = out_stop_r;
    out_count_nxt    = out_count_r;
    out_met_nxt      = out_met_r;

    if (cfg_we) begin
      case (cfg_index)
        REG_DEPOT_X:      depot_x_nxt      = cfg_wdata;
        REG_DEPOT_Y:      depot_y_nxt      = cfg_wdata;
        REG_COVER_TARGET: cover_target_nxt = cfg_wdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (accept && (in_command == CMD_STEP)) begin
          it_id_nxt    = in_supplier_id;
          it_first_nxt = in_first_of_tour;
          it_last_nxt  = in_last_of_tour;
          if (in_first_of_tour || !tour_done_r) begin
            state_nxt = S_RD_CUR;
          end
        end
      end
      S_RD_CUR: begin
        state_nxt = S_RD_PREV;
      end
      S_RD_PREV: begin
        cur_x_nxt = rd_x;
        cur_y_nxt = rd_y;
        cur_m_nxt = rd_m;
        state_nxt = S_GET_PREV;
      end
      S_GET_PREV: begin
        pa_x_nxt  = it_first_r ? depot_x_r : rd_x;
        pa_y_nxt  = it_first_r ? depot_y_r : rd_y;
        state_nxt = S_LEG_GO;
      end
      S_LEG_GO: begin
        state_nxt = S_LEG_WAIT;
      end
      S_LEG_WAIT: begin
        if (drsp.done) begin
          if (it_first_r) begin
            cost_nxt    = COST_W'(drsp.leg);
            covered_nxt = cur_m_r;
            pos_nxt     = '0;
          end else begin
            cost_nxt    = cost_sat;
            covered_nxt = covered_r | cur_m_r;
            pos_nxt     = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
          end
          prev_sup_nxt = it_id_r;
          chunk_nxt    = '0;
          count_nxt    = '0;
          state_nxt    = S_COUNT;
        end
      end
      S_COUNT: begin
        count_nxt = count_r + CNT_W'(chunk_pc);
        chunk_nxt = chunk_r + 1'b1;
        if (chunk_r == CHUNK_LAST) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        emit_met_nxt  = 1'b0;
        emit_stop_nxt = '0;
        if (it_first_r) begin
          tour_done_nxt = it_last_r;
          state_nxt     = it_last_r ? S_EMIT : S_IDLE;
        end else if (count_r >= cover_target_r) begin
          state_nxt = S_RET_GO;
        end else if (it_last_r) begin
          tour_done_nxt = 1'b1;
          state_nxt     = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_RET_GO: begin
        state_nxt = S_RET_WAIT;
      end
      S_RET_WAIT: begin
        if (drsp.done) begin
          cost_nxt      = cost_sat;
          emit_met_nxt  = 1'b1;
          emit_stop_nxt = pos_r;
          tour_done_nxt = 1'b1;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_cost_nxt  = cost_r;
          out_stop_nxt  = emit_stop_r;
          out_count_nxt = count_r;
          out_met_nxt   = emit_met_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      depot_x_r      <= '0;
      depot_y_r      <= '0;
      cover_target_r <= COVER_TARGET_RST;
      covered_r      <= '0;
      cost_r         <= '0;
      prev_sup_r     <= '0;
      pos_r          <= '0;
      tour_done_r    <= 1'b1;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      depot_x_r      <= depot_x_nxt;
      depot_y_r      <= depot_y_nxt;
      cover_target_r <= cover_target_nxt;
      covered_r      <= covered_nxt;
      cost_r         <= cost_nxt;
      prev_sup_r     <= prev_sup_nxt;
      pos_r          <= pos_nxt;
      tour_done_r    <= tour_done_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    it_id_r     <= it_id_nxt;
    it_first_r  <= it_first_nxt;
    it_last_r   <= it_last_nxt;
    cur_x_r     <= cur_x_nxt;
    cur_y_r     <= cur_y_nxt;
    cur_m_r     <= cur_m_nxt;
    pa_x_r      <= pa_x_nxt;
    pa_y_r      <= pa_y_nxt;
    chunk_r     <= chunk_nxt;
    count_r     <= count_nxt;
    emit_met_r  <= emit_met_nxt;
    emit_stop_r <= emit_stop_nxt;
    out_cost_r  <= out_cost_nxt;
    out_stop_r  <= out_stop_nxt;
    out_count_r <= out_count_nxt;
    out_met_r   <= out_met_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_tour_cost     = out_cost_r;
  assign out_stop_position = out_stop_r;
  assign out_covered_count = out_count_r;
  assign out_target_met    = out_met_r;

  a_dist_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> (state_r == S_LEG_WAIT || state_r == S_RET_WAIT))
    else $error("distance result outside a wait state");

  a_return_leg_emits_met: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RET_WAIT && drsp.done) |=> (state_r == S_EMIT && emit_met_r))
    else $error("return leg did not lead to a met result");

  a_met_after_second_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_target_met) |-> (out_stop_position != '0))
    else $error("target met before the second supplier");

endmodule

FILE: tb/covering_tour_cost_evaluator_core_tb.sv
module covering_tour_cost_evaluator_core_tb import ctce_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int DIRECTED_ROWS   = 22;
  localparam int PHASE_REQUESTS  = 195;
  localparam int LONG_TOUR_LEGS  = 70;
  localparam int SETTLE_CYCLES   = 80;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int REPORT_CAP      = 100;

  typedef struct packed {
    logic               command;
    logic [ID_W-1:0]    id;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [MASK_W-1:0]  mask;
    logic               first_flag;
    logic               last_flag;
  } tour_request_t;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [POS_W-1:0]  stop;
    logic [CNT_W-1:0]  count;
    logic              met;
  } tour_score_t;

  typedef struct packed {
    tour_request_t req;
    logic          typed;
    tour_score_t   want;
  } directed_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0]   cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_command = CMD_LOAD;
  logic [ID_W-1:0]      in_supplier_id = '0;
  logic [COORD_W-1:0]   in_coord_x = '0;
  logic [COORD_W-1:0]   in_coord_y = '0;
  logic [MASK_W-1:0]    in_cover_mask = '0;
  logic                 in_first_of_tour = 1'b0;
  logic                 in_last_of_tour = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [COST_W-1:0]    out_tour_cost;
  logic [POS_W-1:0]     out_stop_position;
  logic [CNT_W-1:0]     out_covered_count;
  logic                 out_target_met;

  covering_tour_cost_evaluator_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_supplier_id    (in_supplier_id),
    .in_coord_x        (in_coord_x),
    .in_coord_y        (in_coord_y),
    .in_cover_mask     (in_cover_mask),
    .in_first_of_tour  (in_first_of_tour),
    .in_last_of_tour   (in_last_of_tour),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_tour_cost     (out_tour_cost),
    .out_stop_position (out_stop_position),
    .out_covered_count (out_covered_count),
    .out_target_met    (out_target_met)
  );

  logic [COORD_W-1:0] site_x [64];
  logic [COORD_W-1:0] site_y [64];
  logic [MASK_W-1:0]  site_mask [64];
  bit                 site_loaded [64];
  logic [COORD_W-1:0] depot_x_q = '0;
  logic [COORD_W-1:0] depot_y_q = '0;
  logic [CNT_W-1:0]   target_q = COVER_TARGET_RST;
  logic [MASK_W-1:0]  covered_q = '0;
  logic [COST_W-1:0]  cost_q = '0;
  logic [ID_W-1:0]    prev_site_q = '0;
  logic [POS_W-1:0]   position_q = '0;
  bit                 tour_open = 1'b0;

  tour_score_t   expected_scores [$];
  directed_row_t directed_rows [DIRECTED_ROWS];
  int            counted_requests = 0;
  int            mismatches = 0;
  int            quiet_cycles = 0;
  int            stall_left = 0;
  bit            idle_on = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [DIST_W-1:0] leg_length(input logic [COORD_W-1:0] ax, ay, bx, by);
    logic [33:0] dx;
    logic [33:0] dy;
    logic [33:0] sq;
    logic [33:0] root;
    logic [33:0] trial;
    dx = (ax > bx) ? 34'(ax - bx) : 34'(bx - ax);
    dy = (ay > by) ? 34'(ay - by) : 34'(by - ay);
    sq = dx * dx + dy * dy;
    root = '0;
    for (int b = DIST_W - 1; b >= 0; b--) begin
      trial = root | (34'd1 << b);
      if (trial * trial <= sq) root = trial;
    end
    return root[DIST_W-1:0];
  endfunction

  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [DIST_W-1:0] b);
    logic [COST_W:0] s;
    s = a + b;
    return s[COST_W] ? '1 : s[COST_W-1:0];
  endfunction

  function automatic tour_score_t make_score(input logic [COST_W-1:0] cost,
                                             input logic [POS_W-1:0] stop,
                                             input logic [CNT_W-1:0] count,
                                             input logic met);
    tour_score_t s;
    s.cost = cost;
    s.stop = stop;
    s.count = count;
    s.met = met;
    return s;
  endfunction

  task automatic queue_score(input tour_score_t s);
    expected_scores = {expected_scores, s};
  endtask

  task automatic score_request(input tour_request_t r);
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [CNT_W-1:0]   hits;
    if (r.command == CMD_LOAD) begin
      site_x[r.id] = r.x;
      site_y[r.id] = r.y;
      site_mask[r.id] = r.mask;
      site_loaded[r.id] = 1'b1;
      return;
    end
    if (r.first_flag) begin
      cost_q = COST_W'(leg_length(depot_x_q, depot_y_q, site_x[r.id], site_y[r.id]));
      covered_q = site_mask[r.id];
      prev_site_q = r.id;
      position_q = '0;
      tour_open = 1'b1;
      if (r.last_flag) begin
        tour_open = 1'b0;
        queue_score(make_score(cost_q, '0, CNT_W'($countones(covered_q)), 1'b0));
      end
      return;
    end
    if (!tour_open) return;
    px = site_x[prev_site_q];
    py = site_y[prev_site_q];
    if (position_q != '1) position_q++;
    cost_q = sat_add(cost_q, leg_length(px, py, site_x[r.id], site_y[r.id]));
    covered_q |= site_mask[r.id];
    prev_site_q = r.id;
    hits = CNT_W'($countones(covered_q));
    if (hits >= target_q) begin
      cost_q = sat_add(cost_q, leg_length(site_x[r.id], site_y[r.id], depot_x_q, depot_y_q));
      tour_open = 1'b0;
      queue_score(make_score(cost_q, position_q, hits, 1'b1));
    end else if (r.last_flag) begin
      tour_open = 1'b0;
      queue_score(make_score(cost_q, '0, hits, 1'b0));
    end
  endtask

  function automatic tour_request_t load_req(input logic [ID_W-1:0] id,
                                             input logic [COORD_W-1:0] x, y,
                                             input logic [MASK_W-1:0] mask);
    tour_request_t r;
    r.command = CMD_LOAD;
    r.id = id;
    r.x = x;
    r.y = y;
    r.mask = mask;
    r.first_flag = 1'($urandom_range(0, 1));
    r.last_flag = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic tour_request_t step_req(input logic [ID_W-1:0] id,
                                             input logic first_flag, last_flag);
    tour_request_t r;
    r.command = CMD_STEP;
    r.id = id;
    r.x = COORD_W'($urandom);
    r.y = COORD_W'($urandom);
    r.mask = {$urandom, $urandom};
    r.first_flag = first_flag;
    r.last_flag = last_flag;
    return r;
  endfunction

  function automatic directed_row_t plain_row(input tour_request_t r);
    directed_row_t d;
    d.req = r;
    d.typed = 1'b0;
    d.want = '0;
    return d;
  endfunction

  function automatic directed_row_t scored_row(input tour_request_t r, input tour_score_t want);
    directed_row_t d;
    d.req = r;
    d.typed = 1'b1;
    d.want = want;
    return d;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic logic [MASK_W-1:0] rand_mask();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, 63);
      5: return {$urandom, $urandom};
      default: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [ID_W-1:0] pick_loaded();
    logic [ID_W-1:0] id;
    do id = ID_W'($urandom_range(0, 63)); while (!site_loaded[id]);
    return id;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < REPORT_CAP) $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic push_request(input tour_request_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= r.command;
    in_supplier_id <= r.id;
    in_coord_x <= r.x;
    in_coord_y <= r.y;
    in_cover_mask <= r.mask;
    in_first_of_tour <= r.first_flag;
    in_last_of_tour <= r.last_flag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (r.command == CMD_LOAD || r.first_flag || tour_open) counted_requests++;
    score_request(r);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_DEPOT_X: depot_x_q = val;
      REG_DEPOT_Y: depot_y_q = val;
      REG_COVER_TARGET: target_q = val[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [COORD_W-1:0] dx, dy, target_raw);
    write_reg(REG_DEPOT_X, dx);
    write_reg(REG_DEPOT_Y, dy);
    write_reg(REG_COVER_TARGET, target_raw);
    write_reg(REG_UNUSED, COORD_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic random_burst();
    int  len;
    bit  broken;
    case ($urandom_range(0, 9))
      0, 1: push_request(load_req(ID_W'($urandom_range(0, 63)), rand_coord(), rand_coord(),
                                  rand_mask()));
      2: push_request(step_req(pick_loaded(), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1))));
      default: begin
        len = $urandom_range(1, 10);
        broken = ($urandom_range(0, 7) == 0);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 11) == 0)
            push_request(load_req(ID_W'($urandom_range(0, 63)), rand_coord(), rand_coord(),
                                  rand_mask()));
          push_request(step_req(pick_loaded(), k == 0, (k == len - 1) && !broken));
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    tour_score_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_scores.size() == 0) begin
        report_mismatch($sformatf("unexpected result, cost %0h", out_tour_cost));
      end else begin
        want = expected_scores.pop_front();
        if (out_tour_cost !== want.cost)
          report_mismatch($sformatf("tour_cost %0h, want %0h", out_tour_cost, want.cost));
        if (out_stop_position !== want.stop)
          report_mismatch($sformatf("stop_position %0d, want %0d", out_stop_position, want.stop));
        if (out_covered_count !== want.count)
          report_mismatch($sformatf("covered_count %0d, want %0d", out_covered_count, want.count));
        if (out_target_met !== want.met)
          report_mismatch($sformatf("target_met %0b, want %0b", out_target_met, want.met));
      end
    end
    if (stall_left != 0) stall_left--;
    else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 7);
    out_stall <= (stall_left != 0);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("covering_tour_cost_evaluator_core regression: fail");
      $finish;
    end
  end

  initial begin
    int goal;
    directed_rows = '{
      plain_row(load_req(6'd0, 16'h0000, 16'h0000, 64'h0)),
      plain_row(load_req(6'd63, 16'hFFFF, 16'hFFFF, '1)),
      plain_row(load_req(6'd1, 16'h0300, 16'h0400, 64'h1)),
      plain_row(load_req(6'd2, 16'h0300, 16'h0000, 64'h8000_0000_0000_0000)),
      plain_row(load_req(6'd3, 16'h1234, 16'hABCD, 64'h5555_AAAA_0F0F_F0F0)),
      scored_row(step_req(6'd1, 1'b1, 1'b1), make_score(32'h500, 6'd0, 7'd1, 1'b0)),
      plain_row(step_req(6'd0, 1'b0, 1'b0)),
      plain_row(step_req(6'd1, 1'b1, 1'b0)),
      scored_row(step_req(6'd2, 1'b0, 1'b0), make_score(32'hC00, 6'd1, 7'd2, 1'b1)),
      plain_row(step_req(6'd63, 1'b0, 1'b0)),
      plain_row(step_req(6'd63, 1'b1, 1'b0)),
      scored_row(step_req(6'd0, 1'b0, 1'b1), make_score(32'h2D410, 6'd1, 7'd64, 1'b1)),
      plain_row(step_req(6'd0, 1'b1, 1'b0)),
      scored_row(step_req(6'd0, 1'b0, 1'b1), make_score(32'h0, 6'd0, 7'd0, 1'b0)),
      plain_row(step_req(6'd3, 1'b1, 1'b0)),
      plain_row(step_req(6'd1, 1'b0, 1'b0)),
      plain_row(step_req(6'd63, 1'b0, 1'b1)),
      plain_row(step_req(6'd0, 1'b1, 1'b0)),
      plain_row(step_req(6'd0, 1'b0, 1'b0)),
      plain_row(step_req(6'd1, 1'b1, 1'b0)),
      plain_row(step_req(6'd2, 1'b0, 1'b1)),
      plain_row(load_req(6'd1, 16'h0000, 16'h0400, 64'h0))
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_on = 1'b1;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      push_request(directed_rows[i].req);
      if (directed_rows[i].typed) begin
        void'(expected_scores.pop_back());
        queue_score(directed_rows[i].want);
      end
    end

    for (int p = 0; p < 8; p++) begin
      settle();
      idle_on = (p < 6);
      case (p)
        0: set_config(16'h0000, 16'h0000, 16'd0);
        1: set_config(16'hFFFF, 16'hFFFF, 16'd64);
        2: set_config(rand_coord(), rand_coord(), 16'hFFFF);
        3: set_config(rand_coord(), rand_coord(), 16'd1);
        4: set_config(16'h0000, 16'hFFFF, 16'($urandom_range(0, 16)));
        5: set_config(rand_coord(), rand_coord(), 16'($urandom));
        6: set_config(rand_coord(), rand_coord(), 16'($urandom_range(2, 12)));
        default: set_config(16'hFFFF, 16'h0000, 16'd64);
      endcase
      goal = counted_requests + PHASE_REQUESTS;
      while (counted_requests < goal) random_burst();
    end

    // run a long tour past position 63, then meet the target
    settle();
    set_config(16'h0000, 16'h0000, 16'd64);
    push_request(load_req(6'd20, 16'h0000, 16'h0000, '0));
    push_request(load_req(6'd21, 16'hFFFF, 16'hFFFF, '0));
    push_request(load_req(6'd22, 16'hFFFF, 16'h0000, '1));
    push_request(step_req(6'd21, 1'b1, 1'b0));
    for (int k = 0; k < LONG_TOUR_LEGS; k++)
      push_request(step_req(k[0] ? 6'd21 : 6'd20, 1'b0, 1'b0));
    push_request(step_req(6'd22, 1'b0, 1'b1));

    settle();
    if (mismatches == 0 && expected_scores.size() == 0) begin
      $display("covering_tour_cost_evaluator_core regression: pass");
    end else begin
      $display("covering_tour_cost_evaluator_core regression: fail");
    end
    $finish;
  end

endmodule
